// ===== hdl/drss_pkg.sv =====
// Shared types and constants for the depth row slope segmenter.
// No dependencies; imported by drss_divider and depth_row_slope_segmenter.
`timescale 1ns / 1ps

package drss_pkg;

   localparam int DEPTH_W    = 16;
   localparam int COORD_W    = 9;
   localparam int SLOPE_W    = DEPTH_W + 1;     // right - here, signed
   localparam int DIFF_W     = SLOPE_W + 1;     // slope - running slope, signed
   localparam int MAG_W      = SLOPE_W;         // |diff| fits unsigned in 17 bits
   localparam int COUNT_W    = 10;
   localparam int IN_DATA_W  = 72;              // 66 payload bits, padded to bytes
   localparam int OUT_DATA_W = 80;              // 75 payload bits, padded to bytes
   localparam int DIV_STEPS  = MAG_W;           // one quotient bit per cycle
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
   localparam logic [DEPTH_W-1:0] TOL_RESET = DEPTH_W'(10);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CHECK,
      ST_DIV
   } drss_state_type;

endpackage

// ===== hdl/drss_divider.sv =====
// Restoring serial divider: unsigned magnitude over the run count, one bit a cycle.
// Depends on drss_pkg.
`timescale 1ns / 1ps

module drss_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [drss_pkg::MAG_W-1:0]     dividend,
   input  logic [drss_pkg::COUNT_W-1:0]   divisor,
   output logic                           done,
   output logic [drss_pkg::MAG_W-1:0]     quotient
);
   import drss_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0]     quo_ff, quo_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0]   dsr_ff, dsr_in;
   logic [COUNT_W:0]     shifted;
   logic [COUNT_W:0]     trial;
   logic                 fits;

   // shift the next dividend bit into the partial remainder and try a subtract
   assign shifted = {rem_ff, quo_ff[MAG_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[MAG_W-2:0], fits};
         rem_in = fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/depth_row_slope_segmenter.sv =====
// Depth row slope segmenter, top level. Depends on drss_pkg and drss_divider.
// Flow: a beat that emits or opens a run passes ST_EVAL and ST_CHECK before ready
// returns (it waits in ST_CHECK only while the result register is still held by rsp_tready low);
// a beat that extends a run also waits in ST_DIV for the 17-step serial divider.
// A zero-depth beat is dropped in ST_IDLE and ready stays high. One beat is in work at a time.
// Reset (synchronous, active high): no run open, tolerance 10, output empty.
`timescale 1ns / 1ps

module depth_row_slope_segmenter (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [drss_pkg::DEPTH_W-1:0]      csr_wr_data,   // slope_tolerance
   // pixel stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row[8:0], col[17:9], depth_here[33:18], depth_right[49:34], depth_below[65:50]
   input  logic [drss_pkg::IN_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,     // row_start
   // triangle stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tri_row[8:0], start_column[17:9], start_depth[33:18], end_column[42:34],
   // end_depth[58:43], under_depth[74:59]
   output logic [drss_pkg::OUT_DATA_W-1:0]   rsp_tdata
);
   import drss_pkg::*;

   drss_state_type state_ff, state_in;

   logic [DEPTH_W-1:0]        tol_ff;

   // latched pixel
   logic [COORD_W-1:0]        pix_row_ff, pix_col_ff;
   logic [DEPTH_W-1:0]        pix_here_ff, pix_right_ff, pix_below_ff;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;

   // open run
   logic                      run_open_ff, run_open_in;
   logic signed [SLOPE_W-1:0] run_slope_ff, run_slope_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COORD_W-1:0]        run_row_ff, run_row_in;
   logic [COORD_W-1:0]        run_start_col_ff, run_start_col_in;
   logic [DEPTH_W-1:0]        run_start_depth_ff, run_start_depth_in;
   logic [COORD_W-1:0]        run_end_col_ff, run_end_col_in;
   logic [DEPTH_W-1:0]        run_end_depth_ff, run_end_depth_in;
   logic [DEPTH_W-1:0]        run_under_depth_ff, run_under_depth_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      zero_depth;
   logic [DIFF_W-1:0]         diff_mag;
   logic                      in_tol;
   logic                      out_blocked;
   logic                      div_start;
   logic                      div_done;
   logic [MAG_W-1:0]          div_quo;
   logic                      emit;
   logic                      open_new;
   logic [DIFF_W-1:0]         step;
   logic [DIFF_W-1:0]         slope_sum;
   logic [COORD_W-1:0]        end_col_next;

   assign accept      = req_tvalid && req_tready;
   assign zero_depth  = (req_tdata[33:18] == '0);
   assign diff_mag    = diff_ff[DIFF_W-1] ? (DIFF_W'(0) - DIFF_W'(diff_ff)) : DIFF_W'(diff_ff);
   assign in_tol      = run_open_ff && (diff_mag < {{(DIFF_W-DEPTH_W){1'b0}}, tol_ff});
   assign out_blocked = rsp_valid_ff && !rsp_tready;
   assign end_col_next = pix_col_ff + COORD_W'(1);

   // signed step toward the new slope, truncated toward zero
   assign step      = diff_ff[DIFF_W-1] ? (DIFF_W'(0) - {1'b0, div_quo}) : {1'b0, div_quo};
   assign slope_sum = {run_slope_ff[SLOPE_W-1], run_slope_ff} + step;

   drss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_mag[MAG_W-1:0]),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !zero_depth) state_in = ST_EVAL;
         end
         ST_EVAL: state_in = ST_CHECK;
         ST_CHECK: begin
            if (in_tol)                          state_in = ST_DIV;
            else if (!(run_open_ff && out_blocked)) state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      emit       = 1'b0;
      open_new   = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_CHECK: begin
            if (in_tol) begin
               div_start = 1'b1;
            end else if (!(run_open_ff && out_blocked)) begin
               emit     = run_open_ff;
               open_new = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      slope_in           = slope_ff;
      diff_in            = diff_ff;
      run_open_in        = run_open_ff;
      run_slope_in       = run_slope_ff;
      count_in           = count_ff;
      run_row_in         = run_row_ff;
      run_start_col_in   = run_start_col_ff;
      run_start_depth_in = run_start_depth_ff;
      run_end_col_in     = run_end_col_ff;
      run_end_depth_in   = run_end_depth_ff;
      run_under_depth_in = run_under_depth_ff;
      rsp_data_in        = rsp_data_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_tready;

      if (accept) begin
         slope_in = $signed({1'b0, req_tdata[49:34]}) - $signed({1'b0, req_tdata[33:18]});
         // row start drops the open run even for a zero-depth pixel
         if (req_tuser) run_open_in = 1'b0;
      end

      if (state_ff == ST_EVAL)
         diff_in = {slope_ff[SLOPE_W-1], slope_ff} - {run_slope_ff[SLOPE_W-1], run_slope_ff};

      if (div_start) begin
         run_end_col_in   = end_col_next;
         run_end_depth_in = pix_right_ff;
      end

      if (state_ff == ST_DIV && div_done) begin
         run_slope_in = slope_sum[SLOPE_W-1:0];
         if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_W'(1);
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, run_under_depth_ff, run_end_depth_ff, run_end_col_ff,
                         run_start_depth_ff, run_start_col_ff, run_row_ff};
      end

      if (open_new) begin
         run_open_in        = 1'b1;
         run_row_in         = pix_row_ff;
         run_start_col_in   = pix_col_ff;
         run_start_depth_in = pix_here_ff;
         run_end_col_in     = end_col_next;
         run_end_depth_in   = pix_right_ff;
         run_under_depth_in = pix_below_ff;
         run_slope_in       = slope_ff;
         count_in           = COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= TOL_RESET;
         run_open_ff  <= 1'b0;
         run_slope_ff <= '0;
         count_ff     <= COUNT_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) tol_ff <= csr_wr_data;
         run_open_ff  <= run_open_in;
         run_slope_ff <= run_slope_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         pix_row_ff   <= req_tdata[8:0];
         pix_col_ff   <= req_tdata[17:9];
         pix_here_ff  <= req_tdata[33:18];
         pix_right_ff <= req_tdata[49:34];
         pix_below_ff <= req_tdata[65:50];
      end
      slope_ff           <= slope_in;
      diff_ff            <= diff_in;
      run_row_ff         <= run_row_in;
      run_start_col_ff   <= run_start_col_in;
      run_start_depth_ff <= run_start_depth_in;
      run_end_col_ff     <= run_end_col_in;
      run_end_depth_ff   <= run_end_depth_in;
      run_under_depth_ff <= run_under_depth_in;
      rsp_data_ff        <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
